@@ rtl/qrs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package qrs_pkg;

	localparam int COEF_WIDTH = 16;
	localparam int FRAC_BITS  = 16;
	localparam int OUT_WIDTH  = 34;

	typedef enum logic [1:0] {
		ST_REAL    = 2'd0,
		ST_EQUAL   = 2'd1,
		ST_COMPLEX = 2'd2,
		ST_REJECT  = 2'd3
	} status_t;

endpackage

`default_nettype wire

@@ rtl/quadratic_root_solver_core.sv @@
// Quadratic root solver, fully pipelined.
// Slave channel: one word per coefficient triple (a, b, c), signed integers
// of COEF_WIDTH bits. Master channel: one word per input with the roots in
// signed fixed point (FRAC_BITS fraction bits) and a status code in tuser
// (real distinct, real equal, complex pair, rejected for a of zero).
// Throughput: one word per cycle while the receiver is not stalling. Pipeline
// registers in order: the products, the discriminant, one per result bit in
// the square root pipeline (COEF_WIDTH+FRAC_BITS+1 stages), one to form
// numerators, one per quotient bit in the two parallel restoring dividers
// (COEF_WIDTH+FRAC_BITS+2 stages) and the output register for sign fix and
// saturation.
// Reset clears every valid bit; the pipeline comes out of reset empty.
// When the receiver stalls with a word waiting, the whole pipeline holds and
// s_tready falls; nothing is lost or repeated. While the output register is
// empty or being taken, the pipeline advances and a new word is taken each
// cycle.
`timescale 1ns / 1ps
`default_nettype none

module quadratic_root_solver_core #(
	parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH,
	parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	// coef_a, coef_b, coef_c (COEF_WIDTH bits each), zero padded to bytes
	input  wire logic [((3*COEF_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic      m_tvalid,
	input  wire logic m_tready,
	// root_first, root_second, imag_part (34 bits each), zero padded
	output logic [((3*qrs_pkg::OUT_WIDTH+7)/8)*8-1:0] m_tdata,
	// root_status
	output logic [1:0] m_tuser
);

	localparam int CW    = COEF_WIDTH;
	localparam int FB    = FRAC_BITS;
	localparam int OW    = qrs_pkg::OUT_WIDTH;
	localparam int DW    = 2*CW + 2;
	localparam int MW    = 2*CW + 1;
	localparam int SW    = CW + FB + 1;
	localparam int RW    = 2*SW;
	localparam int RMW   = SW + 2;
	localparam int NBW   = CW + FB + 1;
	localparam int DEN_W = CW + 1;
	localparam int NW    = CW + FB + 2;
	localparam int XW    = NW + 1;
	localparam int DRW   = DEN_W + 1;
	localparam int QW    = NW + 1;
	localparam int EW    = ((QW > OW) ? QW : OW) + 1;
	localparam int OTW   = 3*OW;
	localparam int OPW   = ((OTW+7)/8)*8;

	localparam logic signed [EW-1:0] SAT_HI = (EW'(1) <<< (OW-1)) - EW'(1);
	localparam logic signed [EW-1:0] SAT_LO = -SAT_HI - EW'(1);

	typedef struct packed {
		logic signed [NBW-1:0] nb;
		logic [DEN_W-1:0]      den;
		logic                  aneg;
		logic                  azero;
		logic                  dneg;
		logic                  dzero;
	} side_t;

	typedef struct packed {
		logic [DEN_W-1:0] den;
		logic             xneg;
		logic             yneg;
		logic             azero;
		logic             dneg;
		logic             dzero;
	} dside_t;

	logic en;
	assign en       = ~m_tvalid | m_tready;
	assign s_tready = en;

	// stage 1: products
	logic signed [CW-1:0] in_a, in_b, in_c;
	assign in_a = s_tdata[CW-1:0];
	assign in_b = s_tdata[2*CW-1:CW];
	assign in_c = s_tdata[3*CW-1:2*CW];

	logic                   v_s1;
	logic signed [CW-1:0]   a_s1, b_s1;
	logic signed [2*CW-1:0] bb_s1, ac_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1  <= in_a;
			b_s1  <= in_b;
			bb_s1 <= in_b * in_b;
			ac_s1 <= in_a * in_c;
		end
	end

	// stage 2: discriminant, magnitude, numerator base, denominator
	logic signed [DW-1:0]    d_c;
	logic [MW-1:0]           mag_c;
	logic signed [NBW-1:0]   nb_c;
	logic signed [DEN_W-1:0] a2_c;
	logic [DEN_W-1:0]        den_c;

	assign d_c   = DW'(bb_s1) - (DW'(ac_s1) <<< 2);
	assign mag_c = d_c[DW-1] ? MW'(-d_c) : MW'(d_c);
	assign nb_c  = NBW'(0) - (NBW'(b_s1) <<< FB);
	assign a2_c  = DEN_W'(a_s1) <<< 1;
	assign den_c = a2_c[DEN_W-1] ? DEN_W'(-a2_c) : DEN_W'(a2_c);

	logic          v_s2;
	logic [MW-1:0] mag_s2;
	side_t         side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s2        <= mag_c;
			side_s2.nb    <= nb_c;
			side_s2.den   <= den_c;
			side_s2.aneg  <= a_s1[CW-1];
			side_s2.azero <= (a_s1 == '0);
			side_s2.dneg  <= d_c[DW-1];
			side_s2.dzero <= (d_c == '0);
		end
	end

	// stage 3: square root, one result bit per stage; entry 0 is the feed
	logic           rt_v_s3    [SW+1];
	logic [RW-1:0]  rt_rad_s3  [SW+1];
	logic [RMW-1:0] rt_rem_s3  [SW+1];
	logic [SW-1:0]  rt_root_s3 [SW+1];
	side_t          rt_side_s3 [SW+1];

	assign rt_v_s3[0]    = v_s2;
	assign rt_rad_s3[0]  = RW'(mag_s2) << (2*FB);
	assign rt_rem_s3[0]  = '0;
	assign rt_root_s3[0] = '0;
	assign rt_side_s3[0] = side_s2;

	for (genvar k = 0; k < SW; k++) begin : g_sqrt
		logic [RMW-1:0] sh, tr;
		logic           ge;
		assign sh = {rt_rem_s3[k][RMW-3:0], rt_rad_s3[k][RW-1 -: 2]};
		assign tr = {rt_root_s3[k], 2'b01};
		assign ge = (sh >= tr);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_v_s3[k+1] <= 1'b0;
			end else if (en) begin
				rt_v_s3[k+1] <= rt_v_s3[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rt_rad_s3[k+1]  <= rt_rad_s3[k] << 2;
				rt_rem_s3[k+1]  <= ge ? (sh - tr) : sh;
				rt_root_s3[k+1] <= {rt_root_s3[k][SW-2:0], ge};
				rt_side_s3[k+1] <= rt_side_s3[k];
			end
		end
	end

	// stage 4: numerators; complex pair divides nb and s, real divides nb+s, nb-s
	side_t                sd4_c;
	logic signed [XW-1:0] s_ext, nb_ext, x_c, y_c;

	assign sd4_c  = rt_side_s3[SW];
	assign s_ext  = signed'(XW'(rt_root_s3[SW]));
	assign nb_ext = XW'(sd4_c.nb);
	assign x_c    = sd4_c.dneg ? nb_ext : (nb_ext + s_ext);
	assign y_c    = sd4_c.dneg ? s_ext : (nb_ext - s_ext);

	logic          v_s4;
	logic [NW-1:0] xm_s4, ym_s4;
	dside_t        ds_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= rt_v_s3[SW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xm_s4       <= x_c[XW-1] ? NW'(-x_c) : NW'(x_c);
			ym_s4       <= y_c[XW-1] ? NW'(-y_c) : NW'(y_c);
			ds_s4.den   <= sd4_c.den;
			ds_s4.xneg  <= x_c[XW-1] ^ sd4_c.aneg;
			ds_s4.yneg  <= y_c[XW-1] ^ sd4_c.aneg;
			ds_s4.azero <= sd4_c.azero;
			ds_s4.dneg  <= sd4_c.dneg;
			ds_s4.dzero <= sd4_c.dzero;
		end
	end

	// stage 5: two restoring dividers on magnitudes, one quotient bit per stage
	logic           dv_v_s5  [NW+1];
	logic [NW-1:0]  dv_xn_s5 [NW+1];
	logic [NW-1:0]  dv_yn_s5 [NW+1];
	logic [DRW-1:0] dv_xr_s5 [NW+1];
	logic [DRW-1:0] dv_yr_s5 [NW+1];
	logic [NW-1:0]  dv_xq_s5 [NW+1];
	logic [NW-1:0]  dv_yq_s5 [NW+1];
	dside_t         dv_sd_s5 [NW+1];

	assign dv_v_s5[0]  = v_s4;
	assign dv_xn_s5[0] = xm_s4;
	assign dv_yn_s5[0] = ym_s4;
	assign dv_xr_s5[0] = '0;
	assign dv_yr_s5[0] = '0;
	assign dv_xq_s5[0] = '0;
	assign dv_yq_s5[0] = '0;
	assign dv_sd_s5[0] = ds_s4;

	for (genvar j = 0; j < NW; j++) begin : g_div
		logic [DRW-1:0] xsh, ysh, dext;
		logic           xge, yge;
		assign dext = DRW'(dv_sd_s5[j].den);
		assign xsh  = {dv_xr_s5[j][DRW-2:0], dv_xn_s5[j][NW-1]};
		assign ysh  = {dv_yr_s5[j][DRW-2:0], dv_yn_s5[j][NW-1]};
		assign xge  = (xsh >= dext);
		assign yge  = (ysh >= dext);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s5[j+1] <= 1'b0;
			end else if (en) begin
				dv_v_s5[j+1] <= dv_v_s5[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_xn_s5[j+1] <= dv_xn_s5[j] << 1;
				dv_yn_s5[j+1] <= dv_yn_s5[j] << 1;
				dv_xr_s5[j+1] <= xge ? (xsh - dext) : xsh;
				dv_yr_s5[j+1] <= yge ? (ysh - dext) : ysh;
				dv_xq_s5[j+1] <= {dv_xq_s5[j][NW-2:0], xge};
				dv_yq_s5[j+1] <= {dv_yq_s5[j][NW-2:0], yge};
				dv_sd_s5[j+1] <= dv_sd_s5[j];
			end
		end
	end

	// stage 6: sign fix, saturation, selection
	function automatic logic [OW-1:0] sat_q(input logic [NW-1:0] q, input logic neg);
		logic signed [QW-1:0] v;
		logic signed [EW-1:0] ve;
		v  = neg ? -signed'(QW'(q)) : signed'(QW'(q));
		ve = EW'(v);
		if (ve > SAT_HI) begin
			return OW'(SAT_HI);
		end else if (ve < SAT_LO) begin
			return OW'(SAT_LO);
		end
		return OW'(ve);
	endfunction

	dside_t        sd6_c;
	logic [OW-1:0] qx_c, qy_c;

	assign sd6_c = dv_sd_s5[NW];
	assign qx_c  = sat_q(dv_xq_s5[NW], sd6_c.xneg);
	assign qy_c  = sat_q(dv_yq_s5[NW], sd6_c.yneg);

	logic             v_s6;
	qrs_pkg::status_t status_s6;
	logic [OW-1:0]    first_s6, second_s6, imag_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= dv_v_s5[NW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (sd6_c.azero) begin
				status_s6 <= qrs_pkg::ST_REJECT;
				first_s6  <= '0;
				second_s6 <= '0;
				imag_s6   <= '0;
			end else if (sd6_c.dneg) begin
				status_s6 <= qrs_pkg::ST_COMPLEX;
				first_s6  <= qx_c;
				second_s6 <= qx_c;
				imag_s6   <= qy_c;
			end else begin
				status_s6 <= sd6_c.dzero ? qrs_pkg::ST_EQUAL : qrs_pkg::ST_REAL;
				first_s6  <= qx_c;
				second_s6 <= qy_c;
				imag_s6   <= '0;
			end
		end
	end

	assign m_tvalid = v_s6;
	assign m_tuser  = status_s6;
	assign m_tdata  = {{(OPW-OTW){1'b0}}, imag_s6, second_s6, first_s6};

endmodule

`default_nettype wire
